### rtl/core/ohs_pkg.sv
// Shared types and constants for the open-addressing hash set.
// Used by the front end, back end and top level; depends on nothing else.
package ohs_pkg;

  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int CNT_W = 9;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_DUPABS  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  localparam int HOME_MUL   = 73;
  localparam int PROBE_STEP = 5009;
  localparam int FILL_RESET = 217;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [CNT_W-1:0] occupancy;
  } res_t;

endpackage

### rtl/core/ohs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module ohs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ohs_front.sv
// Front end: accepts commands, masks the key, flags reserved keys, computes
// the home slot and holds the result in a two-entry queue. Uses ohs_pkg.
module ohs_front #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [ohs_pkg::OP_W-1:0]    in_op,
  input  logic [ohs_pkg::KEY_W-1:0]   in_key,
  output logic                        full,
  input  logic                        pop,
  output logic                        q_valid,
  output logic [ohs_pkg::OP_W-1:0]    q_op,
  output logic [KEY_BITS-1:0]         q_key,
  output logic [$clog2(SLOTS)-1:0]    q_home,
  output logic                        q_invalid
);

  localparam int IW = $clog2(SLOTS);

  logic [KEY_BITS-1:0]       key_m;
  logic [IW-1:0]             key_lo;
  logic [IW-1:0]             home;
  logic                      invalid;

  logic [ohs_pkg::OP_W-1:0]  op_q   [2];
  logic [KEY_BITS-1:0]       key_q  [2];
  logic [IW-1:0]             home_q [2];
  logic                      inv_q  [2];
  logic                      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]                cnt_r, cnt_nxt;

  always_comb begin
    key_m  = '0;
    key_lo = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (i < ohs_pkg::KEY_W) key_m[i] = in_key[i];
    end
    for (int i = 0; i < IW; i++) begin
      if (i < KEY_BITS && i < ohs_pkg::KEY_W) key_lo[i] = in_key[i];
    end
    // Multiply by 73 as shifts and adds; only the low index bits matter.
    home    = (key_lo << 6) + (key_lo << 3) + key_lo;
    invalid = (key_m == KEY_BITS'(0)) || (key_m == KEY_BITS'(1));
  end

  assign full      = (cnt_r == 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_op      = op_q[rp_r];
  assign q_key     = key_q[rp_r];
  assign q_home    = home_q[rp_r];
  assign q_invalid = inv_q[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      op_q[wp_r]   <= in_op;
      key_q[wp_r]  <= key_m;
      home_q[wp_r] <= home;
      inv_q[wp_r]  <= invalid;
    end
  end

endmodule

### rtl/core/ohs_back.sv
// Back end: clears the slot table after reset, then runs each queued
// command as a probe sequence over the table RAM. Uses ohs_pkg and ohs_ram.
module ohs_back #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ohs_pkg::CNT_W-1:0]    fill_limit,
  input  logic                         q_valid,
  input  logic [ohs_pkg::OP_W-1:0]     q_op,
  input  logic [KEY_BITS-1:0]          q_key,
  input  logic [$clog2(SLOTS)-1:0]     q_home,
  input  logic                         q_invalid,
  output logic                         pop,
  output logic                         clearing,
  output logic                         res_valid,
  output ohs_pkg::res_t                res
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] STEP = IW'(ohs_pkg::PROBE_STEP % SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [IW:0]   NMAX = (IW+1)'(SLOTS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                    st_r, st_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [IW:0]                   n_r, n_nxt;
  logic [ohs_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [KEY_BITS-1:0]           key_r, key_nxt;
  logic                          inv_r, inv_nxt;
  logic                          hit_r, hit_nxt;
  logic [IW-1:0]                 hit_at_r, hit_at_nxt;
  logic                          free_r, free_nxt;
  logic [IW-1:0]                 free_at_r, free_at_nxt;
  logic [ohs_pkg::CNT_W-1:0]     live_r, live_nxt;
  logic                          res_valid_r, res_valid_nxt;
  ohs_pkg::res_t                 res_r, res_nxt;

  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [KEY_BITS-1:0]           wdata;
  logic [KEY_BITS-1:0]           rdata;

  ohs_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign pop       = (st_r == S_IDLE) && q_valid;
  assign clearing  = (st_r == S_CLR);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    inv_nxt       = inv_r;
    hit_nxt       = hit_r;
    hit_at_nxt    = hit_at_r;
    free_nxt      = free_r;
    free_at_nxt   = free_at_r;
    live_nxt      = live_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = '0;
    case (st_r)
      S_CLR: begin
        we      = 1'b1;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          op_nxt   = q_op;
          key_nxt  = q_key;
          inv_nxt  = q_invalid;
          idx_nxt  = q_home;
          n_nxt    = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          st_nxt   = q_invalid ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        st_nxt = S_CHK;
      end
      S_CHK: begin
        // Empty ends the run; a tombstone is remembered but probing goes on.
        if (rdata == KEY_BITS'(0)) begin
          if (!free_r) begin
            free_nxt    = 1'b1;
            free_at_nxt = idx_r;
          end
          st_nxt = S_FIN;
        end else if (rdata == key_r) begin
          hit_nxt    = 1'b1;
          hit_at_nxt = idx_r;
          st_nxt     = S_FIN;
        end else begin
          if (rdata == KEY_BITS'(1) && !free_r) begin
            free_nxt    = 1'b1;
            free_at_nxt = idx_r;
          end
          n_nxt   = n_r + (IW+1)'(1);
          idx_nxt = idx_r + STEP;
          st_nxt  = (n_nxt == NMAX) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        res_valid_nxt = 1'b1;
        res_nxt.found = hit_r && !inv_r;
        st_nxt        = S_IDLE;
        if (inv_r) begin
          res_nxt.status = ohs_pkg::ST_INVALID;
        end else if (op_r == ohs_pkg::OP_INSERT) begin
          if (hit_r) begin
            res_nxt.status = ohs_pkg::ST_DUPABS;
          end else if (live_r >= fill_limit || !free_r) begin
            res_nxt.status = ohs_pkg::ST_FULL;
          end else begin
            we             = 1'b1;
            waddr          = free_at_r;
            wdata          = key_r;
            live_nxt       = live_r + ohs_pkg::CNT_W'(1);
            res_nxt.status = ohs_pkg::ST_DONE;
          end
        end else if (op_r == ohs_pkg::OP_REMOVE) begin
          if (hit_r) begin
            we             = 1'b1;
            waddr          = hit_at_r;
            wdata          = KEY_BITS'(1);
            if (live_r != '0) live_nxt = live_r - ohs_pkg::CNT_W'(1);
            res_nxt.status = ohs_pkg::ST_DONE;
          end else begin
            res_nxt.status = ohs_pkg::ST_DUPABS;
          end
        end else begin
          res_nxt.status = hit_r ? ohs_pkg::ST_DONE : ohs_pkg::ST_DUPABS;
        end
        res_nxt.occupancy = live_nxt;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      idx_r       <= '0;
      n_r         <= '0;
      live_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      live_r      <= live_nxt;
      res_valid_r <= res_valid_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    inv_r     <= inv_nxt;
    hit_r     <= hit_nxt;
    hit_at_r  <= hit_at_nxt;
    free_r    <= free_nxt;
    free_at_r <= free_at_nxt;
    res_r     <= res_nxt;
  end

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |=> !res_valid_r) else $error("back-to-back result strobes");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NMAX) else $error("probe count exceeded table size");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop) else $error("command taken during table clear");
  a_strobe_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> $past(st_r) == S_FIN) else $error("result outside finish");
`endif

endmodule

### rtl/core/open_addressing_hash_set.sv
// Top level of the open-addressing hash set: fill limit register, front end
// and back end. Uses ohs_pkg, ohs_front and ohs_back.
//
// A command is taken when start is high and busy is low; its one result
// appears for a single cycle with out_valid and cannot be held off. After
// reset the block clears its SLOTS-entry table, one slot a cycle, and holds
// busy high while it clears. Each command is dequeued, then takes one table
// RAM read and its check per probed slot, then a finish step; reserved keys
// skip the probe and go from dequeue straight to finish. Up to two commands
// wait in a queue ahead of the prober. SLOTS must be a power of two.
module open_addressing_hash_set #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ohs_pkg::OP_W-1:0]    in_op,
  input  logic [ohs_pkg::KEY_W-1:0]   in_key,
  output logic                        out_valid,
  output logic [ohs_pkg::ST_W-1:0]    out_status,
  output logic                        out_found,
  output logic [ohs_pkg::CNT_W-1:0]   out_occupancy,
  input  logic                        cfg_we,
  input  logic [ohs_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int IW = $clog2(SLOTS);

  logic [ohs_pkg::CNT_W-1:0] fill_limit_r;
  logic                      q_full, q_valid, q_invalid, pop, clearing;
  logic [ohs_pkg::OP_W-1:0]  q_op;
  logic [KEY_BITS-1:0]       q_key;
  logic [IW-1:0]             q_home;
  ohs_pkg::res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_limit_r <= ohs_pkg::CNT_W'(ohs_pkg::FILL_RESET);
    end else if (cfg_we) begin
      fill_limit_r <= cfg_wdata;
    end
  end

  assign busy = q_full || clearing;

  ohs_front #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !busy),
    .in_op     (in_op),
    .in_key    (in_key),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_key     (q_key),
    .q_home    (q_home),
    .q_invalid (q_invalid)
  );

  ohs_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fill_limit (fill_limit_r),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_key      (q_key),
    .q_home     (q_home),
    .q_invalid  (q_invalid),
    .pop        (pop),
    .clearing   (clearing),
    .res_valid  (out_valid),
    .res        (res)
  );

  assign out_status    = res.status;
  assign out_found     = res.found;
  assign out_occupancy = res.occupancy;

endmodule

### tb/open_addressing_hash_set_tb.sv
// Self-checking testbench for the open-addressing hash set top level.
// It drives directed and random commands, predicts or looks up every result and checks
// it. Depends on ohs_pkg and open_addressing_hash_set.
`timescale 1ns / 1ps

module open_addressing_hash_set_tb;

  localparam int NSLOT      = 256;
  localparam int STEP       = ohs_pkg::PROBE_STEP % NSLOT;
  localparam int CYC_LIMIT  = 4000000;
  localparam int NPHASE     = 6;
  localparam int PHASE_ITEMS = 330;
  // The one op code that has no operation of its own; it acts as a lookup.
  localparam logic [ohs_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [ohs_pkg::OP_W-1:0]  in_op;
  logic [ohs_pkg::KEY_W-1:0] in_key;
  logic                      out_valid;
  logic [ohs_pkg::ST_W-1:0]  out_status;
  logic                      out_found;
  logic [ohs_pkg::CNT_W-1:0] out_occupancy;
  logic                      cfg_we;
  logic [ohs_pkg::CNT_W-1:0] cfg_wdata;

  open_addressing_hash_set #(.SLOTS(NSLOT), .KEY_BITS(ohs_pkg::KEY_W)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_occupancy(out_occupancy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the set.
  logic [ohs_pkg::KEY_W-1:0] shadow_slots [NSLOT];
  logic [ohs_pkg::CNT_W-1:0] shadow_live;
  logic [ohs_pkg::CNT_W-1:0] shadow_limit;

  ohs_pkg::res_t             pending_results [$];
  int                        error_count;
  int                        cycle_count;
  logic [ohs_pkg::KEY_W-1:0] key_pool [320];
  int                        pool_n;
  int                        insert_pct;
  int                        burst_left;

  typedef struct {
    logic [ohs_pkg::OP_W-1:0]  op;
    logic [ohs_pkg::KEY_W-1:0] key;
    bit                        typed;
    ohs_pkg::res_t             res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYC_LIMIT) begin
      $display("open_addressing_hash_set_tb: errors");
      $finish;
    end
  end

  // Computes the result of one command and updates the shadow set.
  function automatic ohs_pkg::res_t apply_command(logic [ohs_pkg::OP_W-1:0] op,
                                                  logic [ohs_pkg::KEY_W-1:0] key);
    ohs_pkg::res_t r;
    logic [7:0] idx;
    bit hit, free_ok;
    logic [7:0] hit_at, free_at;
    r.found = 1'b0;
    if (key == 0 || key == 1) begin
      r.status = ohs_pkg::ST_INVALID;
    end else begin
      idx = key[7:0] * 8'(ohs_pkg::HOME_MUL);
      hit = 0;
      free_ok = 0;
      hit_at = 0;
      free_at = 0;
      for (int n = 0; n < NSLOT; n++) begin
        if (shadow_slots[idx] == 0) begin
          if (!free_ok) begin
            free_ok = 1;
            free_at = idx;
          end
          break;
        end
        if (shadow_slots[idx] == 1) begin
          if (!free_ok) begin
            free_ok = 1;
            free_at = idx;
          end
        end else if (shadow_slots[idx] == key) begin
          hit = 1;
          hit_at = idx;
          break;
        end
        idx = idx + 8'(STEP);
      end
      r.found = hit;
      if (op == ohs_pkg::OP_INSERT) begin
        if (hit) begin
          r.status = ohs_pkg::ST_DUPABS;
        end else if (shadow_live >= shadow_limit || !free_ok) begin
          r.status = ohs_pkg::ST_FULL;
        end else begin
          shadow_slots[free_at] = key;
          shadow_live = shadow_live + 1;
          r.status = ohs_pkg::ST_DONE;
        end
      end else if (op == ohs_pkg::OP_REMOVE) begin
        if (hit) begin
          shadow_slots[hit_at] = 1;
          if (shadow_live > 0) shadow_live = shadow_live - 1;
          r.status = ohs_pkg::ST_DONE;
        end else begin
          r.status = ohs_pkg::ST_DUPABS;
        end
      end else begin
        r.status = hit ? ohs_pkg::ST_DONE : ohs_pkg::ST_DUPABS;
      end
    end
    r.occupancy = shadow_live;
    return r;
  endfunction

  // Presents one command and holds it until the block takes it. Start stays
  // high afterwards so that back-to-back transactions need no gap.
  task automatic issue_command(logic [ohs_pkg::OP_W-1:0] op,
                               logic [ohs_pkg::KEY_W-1:0] key,
                               bit typed, ohs_pkg::res_t typed_res);
    ohs_pkg::res_t r;
    start  <= 1'b1;
    in_op  <= op;
    in_key <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_command(op, key);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_fill_limit(logic [ohs_pkg::CNT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_limit = value;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [ohs_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return ohs_pkg::KEY_W'($urandom_range(0, 1));
    if (sel < 16) return $urandom;
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Most pool keys share a handful of low bytes so that probe chains grow long.
  task automatic fill_pool(int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      key_pool[i] = {$urandom} & 32'hFFFF_FF00;
      key_pool[i][7:0] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(2, 6));
      if (key_pool[i] < 2) key_pool[i] = 32'd2 + i;
    end
  endtask

  function automatic ohs_pkg::res_t mk(logic [ohs_pkg::ST_W-1:0] s, logic f,
                                       logic [ohs_pkg::CNT_W-1:0] o);
    ohs_pkg::res_t r;
    r.status = s;
    r.found = f;
    r.occupancy = o;
    return r;
  endfunction

  always @(posedge clk) begin
    ohs_pkg::res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d found=%0d occupancy=%0d",
                 $time, out_status, out_found, out_occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
          error_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   out_occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [ohs_pkg::CNT_W-1:0] limits [NPHASE];
    logic [ohs_pkg::OP_W-1:0] op;
    int sel;
    ohs_pkg::res_t none;
    limits = '{9'd217, 9'd256, 9'd0, 9'd511, 9'd1, 9'd40};
    none = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = ohs_pkg::OP_LOOKUP;
    in_key = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < NSLOT; i++) shadow_slots[i] = '0;
    shadow_live = '0;
    shadow_limit = 9'(ohs_pkg::FILL_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{ohs_pkg::OP_LOOKUP, 32'd5, 1, mk(ohs_pkg::ST_DUPABS, 0, 0)},
      '{ohs_pkg::OP_INSERT, 32'd0, 1, mk(ohs_pkg::ST_INVALID, 0, 0)},
      '{ohs_pkg::OP_INSERT, 32'd1, 1, mk(ohs_pkg::ST_INVALID, 0, 0)},
      '{ohs_pkg::OP_REMOVE, 32'd1, 1, mk(ohs_pkg::ST_INVALID, 0, 0)},
      '{ohs_pkg::OP_LOOKUP, 32'd0, 1, mk(ohs_pkg::ST_INVALID, 0, 0)},
      '{ohs_pkg::OP_INSERT, 32'd5, 1, mk(ohs_pkg::ST_DONE, 0, 1)},
      '{ohs_pkg::OP_INSERT, 32'd5, 1, mk(ohs_pkg::ST_DUPABS, 1, 1)},
      '{ohs_pkg::OP_LOOKUP, 32'd5, 1, mk(ohs_pkg::ST_DONE, 1, 1)},
      '{OP_SPARE,           32'd5, 1, mk(ohs_pkg::ST_DONE, 1, 1)},
      '{ohs_pkg::OP_REMOVE, 32'd5, 1, mk(ohs_pkg::ST_DONE, 1, 0)},
      '{ohs_pkg::OP_REMOVE, 32'd5, 1, mk(ohs_pkg::ST_DUPABS, 0, 0)},
      '{OP_SPARE,           32'd5, 1, mk(ohs_pkg::ST_DUPABS, 0, 0)},
      '{ohs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1, mk(ohs_pkg::ST_DONE, 0, 1)},
      '{ohs_pkg::OP_INSERT, 32'd2, 0, none},
      '{ohs_pkg::OP_INSERT, 32'd261, 0, none},
      '{ohs_pkg::OP_INSERT, 32'd517, 0, none},
      '{ohs_pkg::OP_INSERT, 32'd5, 0, none},
      '{ohs_pkg::OP_REMOVE, 32'd261, 0, none},
      '{ohs_pkg::OP_LOOKUP, 32'd517, 0, none},
      '{ohs_pkg::OP_INSERT, 32'd773, 0, none},
      '{ohs_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 0, none},
      '{ohs_pkg::OP_REMOVE, 32'hFFFF_FFFF, 0, none},
      '{ohs_pkg::OP_LOOKUP, 32'h8000_0005, 0, none}
    };
    foreach (dir_rows[i]) begin
      issue_command(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);
      sender_pause();
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph != 0) write_fill_limit(limits[ph]);
      // The full-table phase uses a wide pool and heavy inserts so that the
      // probe runs out of free slots.
      fill_pool(ph == 1 ? 300 : $urandom_range(8, 64));
      insert_pct = (ph == 1) ? 75 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < insert_pct) op = ohs_pkg::OP_INSERT;
        else if (sel < insert_pct + 25) op = ohs_pkg::OP_REMOVE;
        else if (sel < 97) op = ohs_pkg::OP_LOOKUP;
        else op = OP_SPARE;
        issue_command(op, pick_key(), 0, none);
        sender_pause();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("open_addressing_hash_set_tb: clean");
    end else begin
      $display("open_addressing_hash_set_tb: errors");
    end
    $finish;
  end

endmodule

### open_addressing_hash_set.f
rtl/core/ohs_pkg.sv
rtl/core/ohs_ram.sv
rtl/core/ohs_front.sv
rtl/core/ohs_back.sv
rtl/core/open_addressing_hash_set.sv
tb/open_addressing_hash_set_tb.sv
